[hdl/ydrd_pkg.sv]
// Package for the detection row decode unit: widths, register codes, shared types
// and fixed-point helpers. No dependencies.

package ydrd_pkg;

  // Number format and field widths
  localparam int FRAC_BITS   = 16;
  localparam int MAX_CLASSES = 256;
  localparam int BOX_FIELDS  = 5;
  localparam int THR_FRAC    = 16;
  localparam int RAW_W       = 8;
  localparam int SCALE_W     = 24;
  localparam int THR_W       = 17;
  localparam int COLS_W      = 9;
  localparam int IMG_W       = 16;
  localparam int OUT_W       = 21;
  localparam int CONF_W      = 24;
  localparam int CLASS_W     = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  // Dequantized values and intermediate products
  localparam int VAL_W       = 9 + FRAC_BITS;
  localparam int WIDE_W      = 2 * VAL_W;
  localparam int CMP_W       = VAL_W + THR_FRAC + 1;
  localparam int COORD_A_W   = VAL_W + 2;
  localparam int COORD_P_W   = COORD_A_W + IMG_W + 1;

  // Column positions within a row
  localparam logic [COLS_W-1:0] COL_CX          = COLS_W'(0);
  localparam logic [COLS_W-1:0] COL_CY          = COLS_W'(1);
  localparam logic [COLS_W-1:0] COL_W           = COLS_W'(2);
  localparam logic [COLS_W-1:0] COL_H           = COLS_W'(3);
  localparam logic [COLS_W-1:0] COL_OBJ         = COLS_W'(4);
  localparam logic [COLS_W-1:0] COL_FIRST_CLASS = COLS_W'(BOX_FIELDS);
  localparam logic [COLS_W-1:0] COL_LIMIT       = COLS_W'(BOX_FIELDS + MAX_CLASSES);
  localparam logic [COLS_W-1:0] COUNT_MAX       = '1;

  // Detection queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZP_OFFSET    = 3'd0,
    CFG_SCALE        = 3'd1,
    CFG_THRESHOLD    = 3'd2,
    CFG_ROW_COLUMNS  = 3'd3,
    CFG_IMAGE_WIDTH  = 3'd4,
    CFG_IMAGE_HEIGHT = 3'd5
  } cfg_reg_e;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CALC,
    BK_LOAD
  } bk_state_e;

  typedef struct packed {
    logic [RAW_W-1:0]   zp_offset;
    logic [SCALE_W-1:0] scale;
    logic [THR_W-1:0]   threshold;
    logic [COLS_W-1:0]  row_columns;
    logic [IMG_W-1:0]   image_width;
    logic [IMG_W-1:0]   image_height;
  } cfg_t;

  // One detection waiting for box scaling
  typedef struct packed {
    logic signed [VAL_W-1:0] cx;
    logic signed [VAL_W-1:0] cy;
    logic signed [VAL_W-1:0] bw;
    logic signed [VAL_W-1:0] bh;
    logic signed [VAL_W-1:0] conf;
    logic [CLASS_W-1:0]      cls;
  } rec_t;

  // Saturate a wide signed value to the dequantized value range
  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = {{(WIDE_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
    lo = ~hi;
    if (x > hi) begin
      return hi[VAL_W-1:0];
    end else if (x < lo) begin
      return lo[VAL_W-1:0];
    end
    return x[VAL_W-1:0];
  endfunction

  // Strict compare of a value against the Q1.16 threshold, aligned exactly
  function automatic logic above_thr(input logic signed [VAL_W-1:0] v,
                                     input logic [THR_W-1:0] thr);
    logic signed [CMP_W-1:0] lhs;
    logic signed [CMP_W-1:0] rhs;
    lhs = CMP_W'(v) <<< THR_FRAC;
    rhs = $signed(CMP_W'(thr)) <<< FRAC_BITS;
    return lhs > rhs;
  endfunction

endpackage

[hdl/ydrd_front.sv]
// Front end: accepts row elements, dequantizes them, tracks box fields and the
// best class product, and pushes qualifying detections. Depends on ydrd_pkg.

module ydrd_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ydrd_pkg::cfg_t                  cfg_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [ydrd_pkg::RAW_W-1:0]      raw_value_i,
  input  logic                            row_end_i,
  input  logic [ydrd_pkg::Q_CNT_W-1:0]    q_count_i,
  output logic                            push_o,
  output ydrd_pkg::rec_t                  rec_o
);
  import ydrd_pkg::*;

  logic                      accept;
  logic [COLS_W-1:0]         cnt_q, cnt_d;
  logic [COLS_W-1:0]         limit;
  logic [Q_CNT_W:0]          fill;

  logic signed [RAW_W:0]     diff;
  logic signed [RAW_W+SCALE_W+1:0] dq_raw;
  logic signed [VAL_W-1:0]   dq;

  // Stage 1: dequantized element
  logic                      s1_valid_q;
  logic signed [VAL_W-1:0]   s1_v_q;
  logic [COLS_W-1:0]         s1_idx_q;
  logic                      s1_in_range_q;
  logic                      s1_last_q;

  // Row fields
  logic signed [VAL_W-1:0]   cx_q, cy_q, bw_q, bh_q, obj_q;
  logic                      rej_q;

  // Stage 2: class product
  logic                      s2_valid_q;
  logic signed [WIDE_W-1:0]  s2_p_q;
  logic signed [WIDE_W-1:0]  p;
  logic                      s2_cls_q;
  logic                      s2_first_q;
  logic [CLASS_W-1:0]        s2_class_q;
  logic                      s2_last_q;

  // Stage 3: best tracking
  logic signed [VAL_W-1:0]   prod;
  logic                      upd;
  logic signed [VAL_W-1:0]   best_q, best_new;
  logic [CLASS_W-1:0]        cls_q, cls_new;
  logic                      has_class_q, has_now;

  // Stall when the queue plus row ends still in flight could fill it
  assign fill = (Q_CNT_W+1)'(q_count_i)
              + (Q_CNT_W+1)'(s1_valid_q & s1_last_q)
              + (Q_CNT_W+1)'(s2_valid_q & s2_last_q);
  assign in_stall_o = (fill >= (Q_CNT_W+1)'(Q_DEPTH));
  assign accept     = in_valid_i & ~in_stall_o;

  // Clamp the row length to the supported class count
  assign limit = (cfg_i.row_columns > COL_LIMIT) ? COL_LIMIT : cfg_i.row_columns;

  // Count columns, saturating, and restart on row end
  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      if (row_end_i) begin
        cnt_d = '0;
      end else if (cnt_q != COUNT_MAX) begin
        cnt_d = cnt_q + COLS_W'(1);
      end
    end
  end

  // Dequantize: (raw - zero point) * scale, saturated
  assign diff   = $signed({1'b0, raw_value_i}) - $signed({1'b0, cfg_i.zp_offset});
  assign dq_raw = diff * $signed({1'b0, cfg_i.scale});
  assign dq     = sat_val(WIDE_W'(dq_raw));

  // Class score times objectness
  assign p = s1_v_q * obj_q;

  // Floor-shift the product and keep the first maximum
  assign prod     = sat_val(s2_p_q >>> FRAC_BITS);
  assign upd      = s2_cls_q & ~rej_q & (s2_first_q | (prod > best_q));
  assign best_new = upd ? prod : best_q;
  assign cls_new  = upd ? s2_class_q : cls_q;
  assign has_now  = has_class_q | (s2_cls_q & s2_first_q);

  // Emit at row end when a class column was seen and both thresholds pass
  assign push_o = s2_valid_q & s2_last_q & has_now & ~rej_q
                & above_thr(best_new, cfg_i.threshold);
  always_comb begin
    rec_o      = '0;
    rec_o.cx   = cx_q;
    rec_o.cy   = cy_q;
    rec_o.bw   = bw_q;
    rec_o.bh   = bh_q;
    rec_o.conf = best_new;
    rec_o.cls  = cls_new;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      has_class_q <= 1'b0;
      rej_q       <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      if (s1_valid_q && s1_in_range_q && (s1_idx_q == COL_OBJ)) begin
        rej_q <= ~above_thr(s1_v_q, cfg_i.threshold);
      end
      if (s2_valid_q) begin
        if (s2_last_q) begin
          has_class_q <= 1'b0;
        end else if (s2_cls_q && s2_first_q) begin
          has_class_q <= 1'b1;
        end
      end
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_v_q        <= dq;
      s1_idx_q      <= cnt_q;
      s1_in_range_q <= (cnt_q < limit);
      s1_last_q     <= row_end_i;
    end
  end

  // Capture box fields and objectness, register the class product
  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_in_range_q) begin
      case (s1_idx_q)
        COL_CX:  cx_q  <= s1_v_q;
        COL_CY:  cy_q  <= s1_v_q;
        COL_W:   bw_q  <= s1_v_q;
        COL_H:   bh_q  <= s1_v_q;
        COL_OBJ: obj_q <= s1_v_q;
        default: ;
      endcase
    end
    if (s1_valid_q) begin
      s2_p_q     <= p;
      s2_cls_q   <= s1_in_range_q & (s1_idx_q >= COL_FIRST_CLASS);
      s2_first_q <= (s1_idx_q == COL_FIRST_CLASS);
      s2_class_q <= CLASS_W'(s1_idx_q - COL_FIRST_CLASS);
      s2_last_q  <= s1_last_q;
    end
  end

  // Best product and its class
  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      best_q <= best_new;
      cls_q  <= cls_new;
    end
  end

endmodule

[hdl/ydrd_queue.sv]
// Short detection queue between the front and back ends.
// Depends on ydrd_pkg.

module ydrd_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  ydrd_pkg::rec_t               data_i,
  input  logic                         pop_i,
  output logic                         valid_o,
  output ydrd_pkg::rec_t               data_o,
  output logic [ydrd_pkg::Q_CNT_W-1:0] count_o
);
  import ydrd_pkg::*;

  rec_t                mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0]  cnt_q;
  logic                do_pop;

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;
  assign do_pop  = pop_i & valid_o;

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
      end
      cnt_q <= cnt_q + Q_CNT_W'(push_i) - Q_CNT_W'(do_pop);
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[hdl/ydrd_back.sv]
// Back end: scales a queued detection to image pixels with one shared multiplier
// and holds the result in the output register. Depends on ydrd_pkg.

module ydrd_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ydrd_pkg::cfg_t                      cfg_i,
  input  logic                                q_valid_i,
  input  ydrd_pkg::rec_t                      q_data_i,
  output logic                                q_pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [ydrd_pkg::OUT_W-1:0]   box_left_o,
  output logic signed [ydrd_pkg::OUT_W-1:0]   box_top_o,
  output logic signed [ydrd_pkg::OUT_W-1:0]   box_width_o,
  output logic signed [ydrd_pkg::OUT_W-1:0]   box_height_o,
  output logic [ydrd_pkg::CONF_W-1:0]         confidence_q16_o,
  output logic [ydrd_pkg::CLASS_W-1:0]        class_index_o
);
  import ydrd_pkg::*;

  // Sequencer steps: a product is formed at each of the first four steps and
  // scaled one step later, so the last step only drains
  localparam logic [2:0] STEP_LEFT   = 3'd0;
  localparam logic [2:0] STEP_TOP    = 3'd1;
  localparam logic [2:0] STEP_WIDTH  = 3'd2;
  localparam logic [2:0] STEP_HEIGHT = 3'd3;
  localparam logic [2:0] STEP_DRAIN  = 3'd4;

  bk_state_e                   state_q, state_d;
  logic [2:0]                  step_q;
  rec_t                        work_q;
  logic                        mul_en, res_en, load;

  logic signed [COORD_A_W-1:0] op_a;
  logic signed [IMG_W:0]       op_b;
  logic signed [COORD_P_W-1:0] prod_q;
  logic                        long_q;
  logic signed [COORD_P_W-1:0] bias, rnd, shifted;
  logic signed [OUT_W-1:0]     coord;
  logic signed [OUT_W-1:0]     left_q, top_q, wid_q;
  logic [CONF_W-1:0]           conf_clamped;
  logic                        out_valid_q;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [COORD_P_W-1:0] x);
    logic signed [COORD_P_W-1:0] hi;
    logic signed [COORD_P_W-1:0] lo;
    hi = {{(COORD_P_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    lo = ~hi;
    if (x > hi) begin
      return hi[OUT_W-1:0];
    end else if (x < lo) begin
      return lo[OUT_W-1:0];
    end
    return x[OUT_W-1:0];
  endfunction

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (q_valid_i) state_d = BK_CALC;
      BK_CALC: if (step_q == STEP_DRAIN) state_d = BK_LOAD;
      BK_LOAD: if (!out_valid_q || !out_stall_i) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    q_pop_o = 1'b0;
    mul_en  = 1'b0;
    res_en  = 1'b0;
    load    = 1'b0;
    case (state_q)
      BK_IDLE: q_pop_o = q_valid_i;
      BK_CALC: begin
        mul_en = (step_q < STEP_DRAIN);
        res_en = (step_q != STEP_LEFT);
      end
      BK_LOAD: load = ~out_valid_q | ~out_stall_i;
      default: ;
    endcase
  end

  // Select multiplier operands for the current step
  always_comb begin
    case (step_q)
      STEP_LEFT:  op_a = (COORD_A_W'(work_q.cx) <<< 1) - COORD_A_W'(work_q.bw);
      STEP_TOP:   op_a = (COORD_A_W'(work_q.cy) <<< 1) - COORD_A_W'(work_q.bh);
      STEP_WIDTH: op_a = COORD_A_W'(work_q.bw);
      default:    op_a = COORD_A_W'(work_q.bh);
    endcase
    if (step_q == STEP_LEFT || step_q == STEP_WIDTH) begin
      op_b = $signed({1'b0, cfg_i.image_width});
    end else begin
      op_b = $signed({1'b0, cfg_i.image_height});
    end
  end

  // Divide by a power of two, truncating toward zero, then saturate
  always_comb begin
    if (long_q) begin
      bias = COORD_P_W'((64'(1) << (FRAC_BITS + 1)) - 64'(1));
    end else begin
      bias = COORD_P_W'((64'(1) << FRAC_BITS) - 64'(1));
    end
    rnd     = prod_q[COORD_P_W-1] ? (prod_q + bias) : prod_q;
    shifted = long_q ? (rnd >>> (FRAC_BITS + 1)) : (rnd >>> FRAC_BITS);
    coord   = sat_out(shifted);
  end

  // Clamp the confidence to its unsigned field
  always_comb begin
    if (work_q.conf < 0) begin
      conf_clamped = '0;
    end else if (work_q.conf > $signed({1'b0, {CONF_W{1'b1}}})) begin
      conf_clamped = '1;
    end else begin
      conf_clamped = CONF_W'(work_q.conf);
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      step_q      <= STEP_LEFT;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (q_pop_o) begin
        step_q <= STEP_LEFT;
      end else if (state_q == BK_CALC) begin
        step_q <= step_q + 3'd1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      work_q <= q_data_i;
    end
    if (mul_en) begin
      prod_q <= op_a * op_b;
      long_q <= (step_q == STEP_LEFT) || (step_q == STEP_TOP);
    end
    if (res_en) begin
      case (step_q)
        STEP_TOP:    left_q <= coord;
        STEP_WIDTH:  top_q  <= coord;
        STEP_HEIGHT: wid_q  <= coord;
        default:     ;
      endcase
    end
    if (load) begin
      box_left_o       <= left_q;
      box_top_o        <= top_q;
      box_width_o      <= wid_q;
      box_height_o     <= coord;
      confidence_q16_o <= conf_clamped;
      class_index_o    <= work_q.cls;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[hdl/yolo_detection_row_decode_unit.sv]
// Top level of the detection row decode unit: configuration registers, front end,
// detection queue and back end. Depends on ydrd_pkg, ydrd_front, ydrd_queue, ydrd_back.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+-------------------------------------------
//   input   | in_valid_i/in_stall_o| raw_value_i, row_end_i
//   output  | out_valid_o/out_stall_i | box_left/top/width/height_o,
//           |                      | confidence_q16_o, class_index_o
//   config  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One row element is taken per cycle while in_stall_o is low, through a three-stage
// front pipeline (dequantize multiply, class-score product, best tracking). The back
// end scales boxes with one shared multiplier and pops the next detection only after
// loading the previous one into the output register; a 4-entry queue sits between the
// two. Input stall rises when queued detections plus row ends still in the front
// pipeline reach 4. Reset restores the register defaults and empties pipeline and queue.

module yolo_detection_row_decode_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [ydrd_pkg::RAW_W-1:0]         raw_value_i,
  input  logic                               row_end_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [ydrd_pkg::OUT_W-1:0]  box_left_o,
  output logic signed [ydrd_pkg::OUT_W-1:0]  box_top_o,
  output logic signed [ydrd_pkg::OUT_W-1:0]  box_width_o,
  output logic signed [ydrd_pkg::OUT_W-1:0]  box_height_o,
  output logic [ydrd_pkg::CONF_W-1:0]        confidence_q16_o,
  output logic [ydrd_pkg::CLASS_W-1:0]       class_index_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ydrd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ydrd_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import ydrd_pkg::*;

  cfg_t               cfg_q;
  logic               push;
  rec_t               push_rec;
  logic               q_valid, q_pop;
  rec_t               q_rec;
  logic [Q_CNT_W-1:0] q_count;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zp_offset    <= RAW_W'(0);
      cfg_q.scale        <= SCALE_W'(65536);
      cfg_q.threshold    <= THR_W'(16384);
      cfg_q.row_columns  <= COLS_W'(85);
      cfg_q.image_width  <= IMG_W'(640);
      cfg_q.image_height <= IMG_W'(640);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_ZP_OFFSET:    cfg_q.zp_offset    <= cfg_data_i[RAW_W-1:0];
        CFG_SCALE:        cfg_q.scale        <= cfg_data_i[SCALE_W-1:0];
        CFG_THRESHOLD:    cfg_q.threshold    <= cfg_data_i[THR_W-1:0];
        CFG_ROW_COLUMNS:  cfg_q.row_columns  <= cfg_data_i[COLS_W-1:0];
        CFG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data_i[IMG_W-1:0];
        CFG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data_i[IMG_W-1:0];
        default:          ;
      endcase
    end
  end

  ydrd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .raw_value_i (raw_value_i),
    .row_end_i   (row_end_i),
    .q_count_i   (q_count),
    .push_o      (push),
    .rec_o       (push_rec)
  );

  ydrd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_rec),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rec),
    .count_o (q_count)
  );

  ydrd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .q_valid_i        (q_valid),
    .q_data_i         (q_rec),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .box_left_o       (box_left_o),
    .box_top_o        (box_top_o),
    .box_width_o      (box_width_o),
    .box_height_o     (box_height_o),
    .confidence_q16_o (confidence_q16_o),
    .class_index_o    (class_index_o)
  );

endmodule

[hdl/ydrd_checker.sv]
// Port-level checks for the detection row decode unit, bound to the top level.
// Depends on ydrd_pkg.

module ydrd_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_stall_o,
  input  logic                               out_valid_o,
  input  logic                               out_stall_i,
  input  logic signed [ydrd_pkg::OUT_W-1:0]  box_left_o,
  input  logic signed [ydrd_pkg::OUT_W-1:0]  box_top_o,
  input  logic signed [ydrd_pkg::OUT_W-1:0]  box_width_o,
  input  logic signed [ydrd_pkg::OUT_W-1:0]  box_height_o,
  input  logic [ydrd_pkg::CONF_W-1:0]        confidence_q16_o,
  input  logic [ydrd_pkg::CLASS_W-1:0]       class_index_o,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_o
);
  import ydrd_pkg::*;

  // Hold a stalled detection unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(box_left_o) && $stable(box_top_o)
      && $stable(box_width_o) && $stable(box_height_o) && $stable(confidence_q16_o)
      && $stable(class_index_o))
    else $error("stalled detection changed");

  // A detection passed the threshold, so its confidence is never zero
  a_conf_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> confidence_q16_o != '0)
    else $error("detection with zero confidence");

  // Handshake outputs are always driven once reset is released
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({in_stall_o, out_valid_o, cfg_ready_o}))
    else $error("unknown value on a handshake output");

  // Configuration writes are always taken
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind yolo_detection_row_decode_unit ydrd_checker u_ydrd_checker (.*);

[verif/yolo_detection_row_decode_unit_tb.sv]
// Self-checking testbench for yolo_detection_row_decode_unit: streams quantized rows,
// predicts each detection in a scoreboard class and compares it field by field.
// Depends on ydrd_pkg and the yolo_detection_row_decode_unit RTL.

module yolo_detection_row_decode_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ydrd_pkg::*;

  localparam int IDLE_LIMIT     = 2000;
  localparam int SETTLE_CYCLES  = 30;
  localparam int RANDOM_ITEMS   = 500;

  typedef struct packed {
    logic signed [OUT_W-1:0] left;
    logic signed [OUT_W-1:0] top;
    logic signed [OUT_W-1:0] width;
    logic signed [OUT_W-1:0] height;
    logic [CONF_W-1:0]       conf;
    logic [CLASS_W-1:0]      cls;
  } detection_t;

  // Tracks row decoding and holds the detections still owed by the block
  class detection_scoreboard;
    int unsigned zero_pt, scale, thr, cols, img_w, img_h;
    int unsigned col_cnt, best_cls;
    longint cx, cy, bw, bh, obj, best_conf;
    bit rejected;
    detection_t pending[$];
    int unsigned mismatches, checked;

    function new();
      zero_pt = 0;
      scale = 65536;
      thr = 16384;
      cols = 85;
      img_w = 640;
      img_h = 640;
      mismatches = 0;
      checked = 0;
      clear_row();
    endfunction

    function void clear_row();
      col_cnt = 0;
      cx = 0;
      cy = 0;
      bw = 0;
      bh = 0;
      obj = 0;
      best_conf = 0;
      best_cls = 0;
      rejected = 0;
    endfunction

    function void set_register(cfg_reg_e idx, int unsigned data);
      case (idx)
        CFG_ZP_OFFSET:    zero_pt = data & 32'hFF;
        CFG_SCALE:        scale = data & 32'hFF_FFFF;
        CFG_THRESHOLD:    thr = data & 32'h1_FFFF;
        CFG_ROW_COLUMNS:  cols = data & 32'h1FF;
        CFG_IMAGE_WIDTH:  img_w = data & 32'hFFFF;
        CFG_IMAGE_HEIGHT: img_h = data & 32'hFFFF;
        default: ;
      endcase
    endfunction

    function longint saturate(longint v, int bits);
      longint hi;
      hi = (64'sd1 <<< (bits - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    // Strict compare of a Q.FRAC_BITS value against the Q1.16 threshold
    function bit above_threshold(longint v);
      return (v <<< THR_FRAC) > (longint'(thr) <<< FRAC_BITS);
    endfunction

    function void note_element(logic [RAW_W-1:0] raw, logic last);
      longint v, prod, left, top, w, h, conf;
      int unsigned lim, taken;
      detection_t d;
      lim = (cols > BOX_FIELDS + MAX_CLASSES) ? BOX_FIELDS + MAX_CLASSES : cols;
      v = saturate((longint'(raw) - longint'(zero_pt)) * longint'(scale), VAL_W);

      // Latch box fields and objectness, track the first maximal class product
      if (col_cnt < lim) begin
        if (col_cnt == COL_CX) cx = v;
        else if (col_cnt == COL_CY) cy = v;
        else if (col_cnt == COL_W) bw = v;
        else if (col_cnt == COL_H) bh = v;
        else if (col_cnt == COL_OBJ) begin
          obj = v;
          rejected = !above_threshold(v);
        end else if (!rejected) begin
          prod = saturate((v * obj) >>> FRAC_BITS, VAL_W);
          if (col_cnt == COL_FIRST_CLASS || prod > best_conf) begin
            best_conf = prod;
            best_cls = col_cnt - BOX_FIELDS;
          end
        end
      end
      if (col_cnt < COUNT_MAX) col_cnt++;

      if (last) begin
        taken = (col_cnt < lim) ? col_cnt : lim;
        if (taken > BOX_FIELDS && !rejected && above_threshold(best_conf)) begin
          left = ((2 * cx - bw) * longint'(img_w)) / (64'sd1 <<< (FRAC_BITS + 1));
          top  = ((2 * cy - bh) * longint'(img_h)) / (64'sd1 <<< (FRAC_BITS + 1));
          w    = (bw * longint'(img_w)) / (64'sd1 <<< FRAC_BITS);
          h    = (bh * longint'(img_h)) / (64'sd1 <<< FRAC_BITS);
          conf = best_conf;
          if (conf > 64'sh FF_FFFF) conf = 64'sh FF_FFFF;
          if (conf < 0) conf = 0;
          d.left   = OUT_W'(saturate(left, OUT_W));
          d.top    = OUT_W'(saturate(top, OUT_W));
          d.width  = OUT_W'(saturate(w, OUT_W));
          d.height = OUT_W'(saturate(h, OUT_W));
          d.conf   = CONF_W'(conf);
          d.cls    = CLASS_W'(best_cls);
          pending = {pending, d};
        end
        clear_row();
      end
    endfunction

    function void check_detection(detection_t got);
      detection_t exp_d;
      if (pending.size() == 0) begin
        $error("unexpected detection: class %0d, confidence %0d", got.cls, got.conf);
        mismatches++;
        return;
      end
      exp_d = pending.pop_front();
      checked++;
      if (got.left !== exp_d.left) begin
        $error("box_left: expected %0d, got %0d", exp_d.left, got.left);
        mismatches++;
      end
      if (got.top !== exp_d.top) begin
        $error("box_top: expected %0d, got %0d", exp_d.top, got.top);
        mismatches++;
      end
      if (got.width !== exp_d.width) begin
        $error("box_width: expected %0d, got %0d", exp_d.width, got.width);
        mismatches++;
      end
      if (got.height !== exp_d.height) begin
        $error("box_height: expected %0d, got %0d", exp_d.height, got.height);
        mismatches++;
      end
      if (got.conf !== exp_d.conf) begin
        $error("confidence_q16: expected %0d, got %0d", exp_d.conf, got.conf);
        mismatches++;
      end
      if (got.cls !== exp_d.cls) begin
        $error("class_index: expected %0d, got %0d", exp_d.cls, got.cls);
        mismatches++;
      end
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [RAW_W-1:0]          raw_value_i;
  logic                      row_end_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic signed [OUT_W-1:0]   box_left_o;
  logic signed [OUT_W-1:0]   box_top_o;
  logic signed [OUT_W-1:0]   box_width_o;
  logic signed [OUT_W-1:0]   box_height_o;
  logic [CONF_W-1:0]         confidence_q16_o;
  logic [CLASS_W-1:0]        class_index_o;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [CFG_IDX_W-1:0]      cfg_index_i;
  logic [CFG_DATA_W-1:0]     cfg_data_i;

  detection_scoreboard detections = new();
  int unsigned in_gap_max = 0;
  int unsigned out_stall_max = 0;
  int unsigned element_count = 0;
  int unsigned random_items = 0;
  int unsigned settings_count = 0;
  int unsigned idle_cycles = 0;

  yolo_detection_row_decode_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .raw_value_i      (raw_value_i),
    .row_end_i        (row_end_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .box_left_o       (box_left_o),
    .box_top_o        (box_top_o),
    .box_width_o      (box_width_o),
    .box_height_o     (box_height_o),
    .confidence_q16_o (confidence_q16_o),
    .class_index_o    (class_index_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort when no channel moves a transfer for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Output side: stall for a random number of cycles, then take one detection
  initial begin
    int unsigned hold;
    detection_t got;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      hold = $urandom_range(0, out_stall_max);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      got = '{box_left_o, box_top_o, box_width_o, box_height_o,
              confidence_q16_o, class_index_o};
      detections.check_detection(got);
    end
  end

  function automatic int unsigned pick_idle_depth();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 17;
    endcase
  endfunction

  // Present one row element after a random gap and hold it until the transfer
  task automatic push_element(logic [RAW_W-1:0] raw, logic last);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    raw_value_i <= raw;
    row_end_i   <= last;
    do @(posedge clk_i); while (in_stall_o);
    detections.note_element(raw, last);
    element_count++;
  endtask

  // Drop input valid, drain all owed detections, then let the pipeline settle
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (detections.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_reg_e idx, int unsigned data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_DATA_W'(data);
    do @(posedge clk_i); while (!cfg_ready_o);
    detections.set_register(idx, data);
  endtask

  task automatic apply_settings(int unsigned zp, int unsigned scl, int unsigned thr,
                                int unsigned cols, int unsigned iw, int unsigned ih);
    wait_idle();
    write_register(CFG_ZP_OFFSET, zp);
    write_register(CFG_SCALE, scl);
    write_register(CFG_THRESHOLD, thr);
    write_register(CFG_ROW_COLUMNS, cols);
    write_register(CFG_IMAGE_WIDTH, iw);
    write_register(CFG_IMAGE_HEIGHT, ih);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    settings_count++;
    in_gap_max = pick_idle_depth();
    out_stall_max = pick_idle_depth();
  endtask

  // One row with random content: objectness leans high, class scores often tie
  task automatic stream_row(int unsigned len, bit counted);
    logic [RAW_W-1:0] raw;
    logic [RAW_W-1:0] top_class;
    top_class = '0;
    for (int unsigned k = 0; k < len; k++) begin
      if (k == COL_OBJ && $urandom_range(0, 9) < 7) begin
        raw = RAW_W'($urandom_range(160, 255));
      end else if (k > COL_FIRST_CLASS && $urandom_range(0, 4) == 0) begin
        raw = top_class;
      end else begin
        raw = RAW_W'($urandom_range(0, 255));
      end
      if (k == COL_FIRST_CLASS || (k > COL_FIRST_CLASS && raw > top_class)) top_class = raw;
      push_element(raw, k == len - 1);
      if (counted && k < detections.cols) random_items++;
    end
  endtask

  task automatic push_row(logic [RAW_W-1:0] vals[$]);
    foreach (vals[k]) push_element(vals[k], k == vals.size() - 1);
  endtask

  initial begin
    int unsigned p, zp, scl, thr, cols, iw, ih, budget, start, len;
    in_valid_i  = 1'b0;
    raw_value_i = '0;
    row_end_i   = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_ZP_OFFSET;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows: scale of 1/256 so a raw byte reads as a fraction
    apply_settings(0, 256, 16384, 7, 640, 480);
    push_row({8'd128, 8'd128, 8'd64, 8'd64, 8'd255, 8'd200, 8'd200});  // tie keeps first
    push_row({8'd255, 8'd0, 8'd255, 8'd0, 8'd16, 8'd255});             // weak objectness
    push_row({8'd255, 8'd255});                                        // ends in box fields
    push_row({8'd0, 8'd0, 8'd0, 8'd0, 8'd255});                        // ends at objectness
    push_row({8'd50, 8'd60, 8'd70, 8'd80, 8'd200, 8'd30, 8'd90, 8'd255, 8'd255});

    // Random phases: the first few pin register extremes, the rest are drawn
    p = 1;
    while (p < 6 || (random_items < RANDOM_ITEMS && p < 80)) begin
      budget = 60;
      case (p)
        1: begin zp = 0;   scl = 256;          thr = 0;     cols = 6;   iw = 65535; ih = 65535; end
        2: begin zp = 128; scl = 24'hFF_FFFF;  thr = 65536; cols = 7;   iw = 1;     ih = 1;     end
        3: begin zp = 255; scl = 0;            thr = 16384; cols = 9;   iw = 640;   ih = 480;
                 budget = 20; end
        4: begin zp = 20;  scl = 300;          thr = 8000;  cols = 261; iw = 0;     ih = 65535; end
        default: begin
          zp   = $urandom_range(0, 40);
          scl  = $urandom_range(200, 1024);
          thr  = $urandom_range(0, 30000);
          cols = ($urandom_range(0, 9) == 0) ? 85 : $urandom_range(6, 14);
          iw   = $urandom_range(1, 65535);
          ih   = $urandom_range(1, 65535);
        end
      endcase
      apply_settings(zp, scl, thr, cols, iw, ih);
      start = random_items;
      do begin
        len = ($urandom_range(0, 99) < 85) ? cols : $urandom_range(1, cols + 4);
        stream_row(len, 1'b1);
      end while (random_items - start < budget);
      p++;
    end

    wait_idle();
    $display("Streamed %0d row elements under %0d register settings, %0d detections checked.",
             element_count, settings_count, detections.checked);
    if (detections.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/ydrd_pkg.sv
hdl/ydrd_front.sv
hdl/ydrd_queue.sv
hdl/ydrd_back.sv
hdl/yolo_detection_row_decode_unit.sv
hdl/ydrd_checker.sv
verif/yolo_detection_row_decode_unit_tb.sv
